### hw/rtl/enu_ned_pkg.sv
package enu_ned_pkg;

  // datapath widths
  localparam int unsigned CordW     = 36;  // CORDIC x and y
  localparam int unsigned ZW        = 20;  // CORDIC angle sum, radians * 65536
  localparam int unsigned AngW      = 15;  // Q3.12 angle out
  localparam int unsigned SqrtW     = 57;  // radicand of the square root
  localparam int unsigned RootSteps = 29;  // result bits of the square root
  localparam int unsigned CordSteps = 16;

  localparam logic signed [AngW-1:0] AngPi     = 15'sd12868;
  localparam logic signed [AngW-1:0] AngHalfPi = 15'sd6434;
  localparam logic signed [ZW-1:0]   HalfPiZ   = 20'sd102944;
  localparam logic signed [CordW-1:0] OneQ28   = 36'sd268435456;

  typedef struct packed {
    logic signed [31:0] north;
    logic signed [31:0] east;
    logic signed [31:0] down;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } pass_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
  } vec_t;

  // operands that wait while the square root runs
  typedef struct packed {
    vec_t                    roll;
    vec_t                    yaw;
    logic signed [CordW-1:0] s;
    pass_t                   pass;
  } angin_t;

  typedef struct packed {
    logic [SqrtW-1:0] rem;
    logic [SqrtW-1:0] root;
  } root_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW-1:0]    z;
    logic                    zero_x;
    logic signed [AngW-1:0]  fixed;
  } cvec_t;

  typedef struct packed {
    cvec_t roll;
    cvec_t pitch;
    cvec_t yaw;
    pass_t pass;
  } cord_t;

  // atan(2^-i) in radians * 65536
  function automatic logic signed [ZW-1:0] atan_lut(input int unsigned i);
    logic signed [ZW-1:0] a;
    case (i)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      15:      a = 20'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/enu_ned_front.sv
module enu_ned_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [15:0]            quat_x_i,
  input  logic signed [15:0]            quat_y_i,
  input  logic signed [15:0]            quat_z_i,
  input  logic signed [15:0]            quat_w_i,
  input  enu_ned_pkg::pass_t            pass_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output enu_ned_pkg::root_t            root_o,
  output enu_ned_pkg::angin_t           ang_o
);

  localparam int unsigned W = enu_ned_pkg::CordW;
  localparam int unsigned N = 4;

  typedef struct packed {
    logic signed [31:0] p10, p32, p11, p22, p33, p02, p13, p30, p12;
  } prod_t;

  // stage handshake chain
  logic [N-1:0] v_q;
  logic [N:0]   rdy;

  assign rdy[N] = ready_i;
  for (genvar k = 0; k < N; k++) begin : g_rdy
    assign rdy[k] = ~v_q[k] | rdy[k+1];
  end
  assign ready_o = rdy[0];
  assign valid_o = v_q[N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < N; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: quaternion products
  prod_t p_d, p_q;
  enu_ned_pkg::pass_t pass1_q;

  always_comb begin
    p_d.p10 = quat_x_i * quat_w_i;
    p_d.p32 = quat_z_i * quat_y_i;
    p_d.p11 = quat_x_i * quat_x_i;
    p_d.p22 = quat_y_i * quat_y_i;
    p_d.p33 = quat_z_i * quat_z_i;
    p_d.p02 = quat_w_i * quat_y_i;
    p_d.p13 = quat_x_i * quat_z_i;
    p_d.p30 = quat_z_i * quat_w_i;
    p_d.p12 = quat_x_i * quat_y_i;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      p_q     <= p_d;
      pass1_q <= pass_i;
    end
  end

  // stage 2: atan2 operands and clamped asin argument
  enu_ned_pkg::angin_t a2_d, a2_q;
  logic signed [W-1:0] s_raw;

  always_comb begin
    a2_d.roll.y = (W'(p_q.p10) + W'(p_q.p32)) <<< 1;
    a2_d.roll.x = enu_ned_pkg::OneQ28 - ((W'(p_q.p11) + W'(p_q.p22)) <<< 1);
    a2_d.yaw.y  = (W'(p_q.p30) + W'(p_q.p12)) <<< 1;
    a2_d.yaw.x  = enu_ned_pkg::OneQ28 - ((W'(p_q.p22) + W'(p_q.p33)) <<< 1);
    s_raw       = (W'(p_q.p02) - W'(p_q.p13)) <<< 1;
    if (s_raw > enu_ned_pkg::OneQ28) begin
      a2_d.s = enu_ned_pkg::OneQ28;
    end else if (s_raw < -enu_ned_pkg::OneQ28) begin
      a2_d.s = -enu_ned_pkg::OneQ28;
    end else begin
      a2_d.s = s_raw;
    end
    a2_d.pass = pass1_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) a2_q <= a2_d;
  end

  // stage 3: square of the asin argument
  enu_ned_pkg::angin_t  a3_q;
  logic signed [29:0]   s30;
  logic signed [59:0]   sq_full;
  logic [enu_ned_pkg::SqrtW-1:0] sq_d, sq_q;

  assign s30     = a2_q.s[29:0];
  assign sq_full = s30 * s30;
  assign sq_d    = sq_full[enu_ned_pkg::SqrtW-1:0];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      a3_q <= a2_q;
      sq_q <= sq_d;
    end
  end

  // stage 4: radicand 1 - s^2 in Q56
  enu_ned_pkg::root_t r_d, r_q;
  enu_ned_pkg::angin_t a4_q;

  always_comb begin
    r_d.rem  = (enu_ned_pkg::SqrtW'(1) << 56) - sq_q;
    r_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      r_q  <= r_d;
      a4_q <= a3_q;
    end
  end

  assign root_o = r_q;
  assign ang_o  = a4_q;

endmodule

### hw/rtl/enu_ned_isqrt_step.sv
module enu_ned_isqrt_step #(
  parameter int unsigned Level = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  enu_ned_pkg::root_t  root_i,
  input  enu_ned_pkg::angin_t ang_i,
  output logic                valid_o,
  input  logic                ready_i,
  output enu_ned_pkg::root_t  root_o,
  output enu_ned_pkg::angin_t ang_o
);

  localparam int unsigned SW = enu_ned_pkg::SqrtW;
  localparam logic [SW-1:0] Bit = SW'(1) << (2 * Level);

  logic                v_q;
  enu_ned_pkg::root_t  r_d, r_q;
  enu_ned_pkg::angin_t a_q;
  logic [SW:0]         trial;

  assign ready_o = ~v_q | ready_i;
  assign valid_o = v_q;

  // one restoring square root digit
  always_comb begin
    trial = {1'b0, root_i.root} + {1'b0, Bit};
    if ({1'b0, root_i.rem} >= trial) begin
      r_d.rem  = root_i.rem - trial[SW-1:0];
      r_d.root = (root_i.root >> 1) + Bit;
    end else begin
      r_d.rem  = root_i.rem;
      r_d.root = root_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      r_q <= r_d;
      a_q <= ang_i;
    end
  end

  assign root_o = r_q;
  assign ang_o  = a_q;

endmodule

### hw/rtl/enu_ned_prerot.sv
module enu_ned_prerot (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  enu_ned_pkg::root_t  root_i,
  input  enu_ned_pkg::angin_t ang_i,
  output logic                valid_o,
  input  logic                ready_i,
  output enu_ned_pkg::cord_t  cord_o
);

  localparam int unsigned W  = enu_ned_pkg::CordW;
  localparam int unsigned RW = enu_ned_pkg::RootSteps;

  // quadrant fold into the right half plane, x == 0 handled on the side
  function automatic enu_ned_pkg::cvec_t fold(input logic signed [W-1:0] y,
                                              input logic signed [W-1:0] x);
    enu_ned_pkg::cvec_t c;
    c.zero_x = (x == '0);
    if (y > 0) begin
      c.fixed = enu_ned_pkg::AngHalfPi;
    end else if (y < 0) begin
      c.fixed = -enu_ned_pkg::AngHalfPi;
    end else begin
      c.fixed = '0;
    end
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.z = enu_ned_pkg::HalfPiZ;
      end else begin
        c.x = -y;
        c.y = x;
        c.z = -enu_ned_pkg::HalfPiZ;
      end
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    return c;
  endfunction

  logic                v_q;
  enu_ned_pkg::cord_t  c_d, c_q;
  logic signed [W-1:0] cos_x;

  assign ready_o = ~v_q | ready_i;
  assign valid_o = v_q;

  assign cos_x = {{(W-RW){1'b0}}, root_i.root[RW-1:0]};

  always_comb begin
    c_d.roll  = fold(ang_i.roll.y, ang_i.roll.x);
    c_d.pitch = fold(ang_i.s, cos_x);
    c_d.yaw   = fold(ang_i.yaw.y, ang_i.yaw.x);
    c_d.pass  = ang_i.pass;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) c_q <= c_d;
  end

  assign cord_o = c_q;

endmodule

### hw/rtl/enu_ned_cordic_step.sv
module enu_ned_cordic_step #(
  parameter int unsigned Step = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  enu_ned_pkg::cord_t cord_i,
  output logic               valid_o,
  input  logic               ready_i,
  output enu_ned_pkg::cord_t cord_o
);

  localparam logic signed [enu_ned_pkg::ZW-1:0] Angle = enu_ned_pkg::atan_lut(Step);

  // one vectoring micro-rotation
  function automatic enu_ned_pkg::cvec_t rot(input enu_ned_pkg::cvec_t a);
    enu_ned_pkg::cvec_t r;
    r = a;
    if (a.y >= 0) begin
      r.x = a.x + (a.y >>> Step);
      r.y = a.y - (a.x >>> Step);
      r.z = a.z + Angle;
    end else begin
      r.x = a.x - (a.y >>> Step);
      r.y = a.y + (a.x >>> Step);
      r.z = a.z - Angle;
    end
    return r;
  endfunction

  logic               v_q;
  enu_ned_pkg::cord_t c_d, c_q;

  assign ready_o = ~v_q | ready_i;
  assign valid_o = v_q;

  always_comb begin
    c_d.roll  = rot(cord_i.roll);
    c_d.pitch = rot(cord_i.pitch);
    c_d.yaw   = rot(cord_i.yaw);
    c_d.pass  = cord_i.pass;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) c_q <= c_d;
  end

  assign cord_o = c_q;

endmodule

### hw/rtl/enu_to_ned_pose_converter.sv
// The pipeline has 51 register stages: 4 product/radicand stages, 29 square root
// digit stages, 1 quadrant fold, 16 CORDIC stages, 1 output.
// Throughput: one pose per cycle unless m_axis_tready stalls it; every stage holds
// its own valid bit and takes new data whenever it is empty or its successor moves.
// Reset: rst_ni clears all valid bits asynchronously; payload is not reset.
module enu_to_ned_pose_converter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // east_pos, north_pos, up_pos, quat_x, quat_y, quat_z, quat_w, vel_x, vel_y, vel_z
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // north_out, east_out, down_out, roll_out, pitch_out, yaw_out,
  // vel_x_out, vel_y_out, vel_z_out, 3 zero bits
  output logic [239:0] m_axis_tdata
);

  localparam int unsigned AW = enu_ned_pkg::AngW;
  localparam int unsigned ZW = enu_ned_pkg::ZW;
  localparam int unsigned RS = enu_ned_pkg::RootSteps;
  localparam int unsigned CS = enu_ned_pkg::CordSteps;

  // negate with saturation at the positive limit
  function automatic logic signed [31:0] sat_neg(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == 32'sh8000_0000) begin
      r = 32'sh7fff_ffff;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // round radians*65536 to Q3.12, clamp to [-pi, pi]; the fixed angle where x == 0
  function automatic logic signed [AW-1:0] fin_ang(input enu_ned_pkg::cvec_t c);
    logic signed [ZW-1:0] zr;
    logic signed [AW-1:0] a;
    zr = (c.z + ZW'(8)) >>> 4;
    if (zr > ZW'(enu_ned_pkg::AngPi)) begin
      a = enu_ned_pkg::AngPi;
    end else if (zr < -ZW'(enu_ned_pkg::AngPi)) begin
      a = -enu_ned_pkg::AngPi;
    end else begin
      a = zr[AW-1:0];
    end
    if (c.zero_x) a = c.fixed;
    return a;
  endfunction

  // input unpack
  enu_ned_pkg::pass_t pass_in;
  logic signed [15:0] qx, qy, qz, qw;

  assign qx = s_axis_tdata[111:96];
  assign qy = s_axis_tdata[127:112];
  assign qz = s_axis_tdata[143:128];
  assign qw = s_axis_tdata[159:144];

  always_comb begin
    pass_in.north = s_axis_tdata[63:32];
    pass_in.east  = s_axis_tdata[31:0];
    pass_in.down  = sat_neg(s_axis_tdata[95:64]);
    pass_in.vel_x = s_axis_tdata[191:160];
    pass_in.vel_y = sat_neg(s_axis_tdata[223:192]);
    pass_in.vel_z = sat_neg(s_axis_tdata[255:224]);
  end

  // products, operands, radicand
  logic                 sq_v [RS+1];
  logic                 sq_r [RS+1];
  enu_ned_pkg::root_t   sq_rt [RS+1];
  enu_ned_pkg::angin_t  sq_an [RS+1];

  enu_ned_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .quat_x_i (qx),
    .quat_y_i (qy),
    .quat_z_i (qz),
    .quat_w_i (qw),
    .pass_i   (pass_in),
    .valid_o  (sq_v[0]),
    .ready_i  (sq_r[0]),
    .root_o   (sq_rt[0]),
    .ang_o    (sq_an[0])
  );

  // square root, one result bit per stage, top bit first
  for (genvar j = 0; j < RS; j++) begin : g_sqrt
    enu_ned_isqrt_step #(.Level(RS - 1 - j)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[j]),
      .ready_o (sq_r[j]),
      .root_i  (sq_rt[j]),
      .ang_i   (sq_an[j]),
      .valid_o (sq_v[j+1]),
      .ready_i (sq_r[j+1]),
      .root_o  (sq_rt[j+1]),
      .ang_o   (sq_an[j+1])
    );
  end

  // quadrant fold
  logic               cd_v [CS+1];
  logic               cd_r [CS+1];
  enu_ned_pkg::cord_t cd   [CS+1];

  enu_ned_prerot u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v[RS]),
    .ready_o (sq_r[RS]),
    .root_i  (sq_rt[RS]),
    .ang_i   (sq_an[RS]),
    .valid_o (cd_v[0]),
    .ready_i (cd_r[0]),
    .cord_o  (cd[0])
  );

  // three CORDICs side by side
  for (genvar i = 0; i < CS; i++) begin : g_cordic
    enu_ned_cordic_step #(.Step(i)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cd_v[i]),
      .ready_o (cd_r[i]),
      .cord_i  (cd[i]),
      .valid_o (cd_v[i+1]),
      .ready_i (cd_r[i+1]),
      .cord_o  (cd[i+1])
    );
  end

  // output stage: rounding, yaw offset and wrap
  logic                  out_v_q;
  logic signed [AW-1:0]  roll_d, pitch_d, yaw_d, psi;
  logic signed [AW-1:0]  roll_q, pitch_q, yaw_q;
  logic signed [AW+1:0]  yw;
  enu_ned_pkg::pass_t    pass_q;

  assign cd_r[CS] = ~out_v_q | m_axis_tready;

  always_comb begin
    pitch_d = fin_ang(cd[CS].roll);
    roll_d  = fin_ang(cd[CS].pitch);
    psi     = fin_ang(cd[CS].yaw);
    yw      = (AW+2)'(enu_ned_pkg::AngHalfPi) - (AW+2)'(psi);
    if (yw < -(AW+2)'(enu_ned_pkg::AngPi)) begin
      yw = yw + ((AW+2)'(enu_ned_pkg::AngPi) <<< 1);
    end
    if (yw > (AW+2)'(enu_ned_pkg::AngPi)) begin
      yw = yw - ((AW+2)'(enu_ned_pkg::AngPi) <<< 1);
    end
    yaw_d = yw[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cd_r[CS]) begin
      out_v_q <= cd_v[CS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cd_r[CS]) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
      pass_q  <= cd[CS].pass;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b000, pass_q.vel_z, pass_q.vel_y, pass_q.vel_x,
                          yaw_q, pitch_q, roll_q,
                          pass_q.down, pass_q.east, pass_q.north};

  // roll and yaw angles stay in [-pi, pi]
  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (roll_q <= enu_ned_pkg::AngPi && roll_q >= -enu_ned_pkg::AngPi))
    else $error("roll out of range");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (yaw_q <= enu_ned_pkg::AngPi && yaw_q >= -enu_ned_pkg::AngPi))
    else $error("yaw out of range");

  // an empty output register lets the whole chain move
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

### tb/enu_to_ned_pose_converter_tb.sv
module enu_to_ned_pose_converter_tb;

  localparam int unsigned AngW = enu_ned_pkg::AngW;
  localparam int unsigned Latency = 52;
  localparam int unsigned RandItems = 1460;
  localparam int HoldCycles = 300;
  localparam longint CycleLimit = 400000;
  localparam longint OneQ28L = 64'sd268435456;
  localparam longint HalfPiQ16 = 102944;

  typedef struct packed {
    logic signed [31:0] vel_z;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [15:0] qw;
    logic signed [15:0] qz;
    logic signed [15:0] qy;
    logic signed [15:0] qx;
    logic signed [31:0] up;
    logic signed [31:0] north;
    logic signed [31:0] east;
  } pose_in_t;

  typedef struct packed {
    logic [2:0]             pad;
    logic signed [31:0]     vel_z;
    logic signed [31:0]     vel_y;
    logic signed [31:0]     vel_x;
    logic signed [AngW-1:0] yaw;
    logic signed [AngW-1:0] pitch;
    logic signed [AngW-1:0] roll;
    logic signed [31:0]     down;
    logic signed [31:0]     east;
    logic signed [31:0]     north;
  } pose_out_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [239:0] m_axis_tdata;

  pose_out_t ned_q[$];
  int        n_err = 0;
  int        n_sent = 0;
  int        n_recv = 0;
  longint    cycle = 0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_len = 0;

  enu_to_ned_pose_converter dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #6 clk_i = ~clk_i;

  // ---------------- predictor ----------------
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint neg_sat(longint v);
    longint r;
    r = -v;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    return r;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0) return (y > 0) ? 6434 : (y < 0) ? -6434 : 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HalfPiQ16;
      end else begin
        t = x; x = -y; y = t; z = -HalfPiQ16;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += enu_ned_pkg::atan_lut(i);
      end else begin
        x -= ys; y += xs; z -= enu_ned_pkg::atan_lut(i);
      end
    end
    z = fshr(z + 8, 4);
    if (z > 12868) z = 12868;
    if (z < -12868) z = -12868;
    return z;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic pose_out_t predict_ned(pose_in_t p);
    pose_out_t o;
    longint q0, q1, q2, q3, s, phi, th, psi, yw;
    q1 = p.qx; q2 = p.qy; q3 = p.qz; q0 = p.qw;
    phi = vec_angle(2 * (q1 * q0 + q3 * q2), OneQ28L - 2 * (q1 * q1 + q2 * q2));
    s = 2 * (q0 * q2 - q1 * q3);
    if (s > OneQ28L) s = OneQ28L;
    if (s < -OneQ28L) s = -OneQ28L;
    th = vec_angle(s, int_root((64'd1 << 56) - longint'(s * s)));
    psi = vec_angle(2 * (q3 * q0 + q1 * q2), OneQ28L - 2 * (q2 * q2 + q3 * q3));
    yw = 6434 - psi;
    if (yw < -12868) yw += 25736;
    if (yw > 12868) yw -= 25736;
    o = '0;
    o.north = p.north;
    o.east  = p.east;
    o.down  = 32'(neg_sat(p.up));
    o.roll  = AngW'(th);
    o.pitch = AngW'(phi);
    o.yaw   = AngW'(yw);
    o.vel_x = p.vel_x;
    o.vel_y = 32'(neg_sat(p.vel_y));
    o.vel_z = 32'(neg_sat(p.vel_z));
    return o;
  endfunction

  // ---------------- sender ----------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // tvalid drops only when a gap follows, so back to back transactions keep it high
  task automatic send_pose(pose_in_t p, bit no_gap = 1'b0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 256'(p);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ned_q.insert(ned_q.size(), predict_ned(p));
    n_sent++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_q();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'(-16384);
    if (r == 1) return 16'(16384);
    if (r == 2) return 16'($urandom_range(0, 60)) - 16'd30;
    if (r < 5) return 16'($urandom);
    return 16'(signed'($urandom_range(0, 32768)) - 16384);
  endfunction

  // roughly unit quaternion: three random parts, the fourth fills up the norm
  function automatic pose_in_t rand_pose(bit unit_q);
    pose_in_t p;
    int a, b, c, rr;
    p.east = rand_word(); p.north = rand_word(); p.up = rand_word();
    p.vel_x = rand_word(); p.vel_y = rand_word(); p.vel_z = rand_word();
    if (unit_q) begin
      a = signed'($urandom_range(0, 18918)) - 9459;
      b = signed'($urandom_range(0, 18918)) - 9459;
      c = signed'($urandom_range(0, 18918)) - 9459;
      rr = 268435456 - a * a - b * b - c * c;
      rr = (rr > 0) ? int'(int_root(longint'(rr))) : 0;
      if ($urandom_range(0, 1)) rr = -rr;
      case ($urandom_range(0, 3))
        0: begin p.qx = 16'(rr); p.qy = 16'(a); p.qz = 16'(b); p.qw = 16'(c); end
        1: begin p.qx = 16'(a); p.qy = 16'(rr); p.qz = 16'(b); p.qw = 16'(c); end
        2: begin p.qx = 16'(a); p.qy = 16'(b); p.qz = 16'(rr); p.qw = 16'(c); end
        default: begin p.qx = 16'(a); p.qy = 16'(b); p.qz = 16'(c); p.qw = 16'(rr); end
      endcase
    end else begin
      p.qx = rand_q(); p.qy = rand_q(); p.qz = rand_q(); p.qw = rand_q();
    end
    return p;
  endfunction

  function automatic pose_in_t mk_pose(int qx, int qy, int qz, int qw,
                                       logic [31:0] w0, logic [31:0] w1);
    pose_in_t p;
    p.east = w0; p.north = w1; p.up = w0;
    p.vel_x = w1; p.vel_y = w0; p.vel_z = w1;
    p.qx = 16'(qx); p.qy = 16'(qy); p.qz = 16'(qz); p.qw = 16'(qw);
    return p;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    send_pose(mk_pose(0, 0, 0, 16384, 32'h8000_0000, 32'h7fff_ffff));
    send_pose(mk_pose(0, 0, 0, 0, 32'h0, 32'hffff_ffff));
    send_pose(mk_pose(0, 0, 16384, 0, 32'h7fff_ffff, 32'h8000_0000));
    send_pose(mk_pose(0, 0, -16384, 0, 32'h1, 32'h0));
    send_pose(mk_pose(16384, 0, 0, 0, 32'hffff_ffff, 32'h8000_0001));
    send_pose(mk_pose(0, 16384, 0, 0, 32'h5555_5555, 32'haaaa_aaaa));
    send_pose(mk_pose(0, 11585, 0, 11585, 32'h8000_0000, 32'h8000_0000));
    send_pose(mk_pose(0, -11585, 0, 11585, 32'h7fff_ffff, 32'h7fff_ffff));
    send_pose(mk_pose(0, 16384, 0, 16384, 32'h1234_5678, 32'h8765_4321));
    send_pose(mk_pose(-16384, 16384, -16384, 16384, 32'h0, 32'h0));
    send_pose(mk_pose(16384, -16384, 16384, -16384, 32'h1, 32'h2));
    send_pose(mk_pose(0, 0, 11585, 11585, 32'h3, 32'h4));
    send_pose(mk_pose(0, 0, 11585, -11585, 32'h5, 32'h6));
    send_pose(mk_pose(0, 0, 16383, 1, 32'h7, 32'h8));
    send_pose(mk_pose(0, 0, 16383, -1, 32'h9, 32'ha));
    send_pose(mk_pose(11585, 0, 0, 11585, 32'hb, 32'hc));
    send_pose(mk_pose(-32768, 32767, -32768, 32767, 32'hd, 32'he));
    send_pose(mk_pose(32767, -32768, 32767, -32768, 32'hf, 32'h10));
    send_pose(mk_pose(-1, -1, -1, -1, 32'hffff_fffe, 32'h11));
  endtask

  task automatic test_random();
    for (int i = 0; i < RandItems; i++)
      send_pose(rand_pose($urandom_range(0, 3) != 0));
  endtask

  // back to back while the sink is held off, so the pipeline backs up
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 120; i++) send_pose(rand_pose(1'b1), 1'b1);
  endtask

  // ---------------- sink and checker ----------------
  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      m_axis_tready <= 1'b0;
      hold_len <= hold_len - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_len <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < 70) ? 1'b1 :
                       ($urandom_range(0, 9) == 0) ? 1'b0 : 1'($urandom_range(0, 1));
    end
  end

  always @(posedge clk_i) begin
    pose_out_t got, want;
    cycle <= cycle + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pose_out_t'(m_axis_tdata);
      n_recv++;
      if (ned_q.size() == 0) begin
        $error("result with no pose pending");
        n_err++;
      end else begin
        want = ned_q.pop_front();
        if (got.north !== want.north) begin
          $error("north_out exp %0d got %0d", want.north, got.north); n_err++;
        end
        if (got.east !== want.east) begin
          $error("east_out exp %0d got %0d", want.east, got.east); n_err++;
        end
        if (got.down !== want.down) begin
          $error("down_out exp %0d got %0d", want.down, got.down); n_err++;
        end
        if (got.roll !== want.roll) begin
          $error("roll_out exp %0d got %0d", want.roll, got.roll); n_err++;
        end
        if (got.pitch !== want.pitch) begin
          $error("pitch_out exp %0d got %0d", want.pitch, got.pitch); n_err++;
        end
        if (got.yaw !== want.yaw) begin
          $error("yaw_out exp %0d got %0d", want.yaw, got.yaw); n_err++;
        end
        if (got.vel_x !== want.vel_x) begin
          $error("vel_x_out exp %0d got %0d", want.vel_x, got.vel_x); n_err++;
        end
        if (got.vel_y !== want.vel_y) begin
          $error("vel_y_out exp %0d got %0d", want.vel_y, got.vel_y); n_err++;
        end
        if (got.vel_z !== want.vel_z) begin
          $error("vel_z_out exp %0d got %0d", want.vel_z, got.vel_z); n_err++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycle > CycleLimit) begin
      $display("timeout after %0d cycles, %0d poses pending", cycle, ned_q.size());
      $display("enu_to_ned_pose_converter_tb NOT OK");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (ned_q.size() != 0) @(posedge clk_i);
    repeat (2 * Latency) @(posedge clk_i);
    $display("sent %0d poses (corner quaternions, unit and raw random, stalled sink),",
             n_sent);
    $display("checked %0d NED results, %0d field mismatches", n_recv, n_err);
    if (n_err == 0)
      $display("enu_to_ned_pose_converter_tb OK");
    else
      $display("enu_to_ned_pose_converter_tb NOT OK");
    $finish;
  end

endmodule

### files.f
hw/rtl/enu_ned_pkg.sv
hw/rtl/enu_ned_front.sv
hw/rtl/enu_ned_isqrt_step.sv
hw/rtl/enu_ned_prerot.sv
hw/rtl/enu_ned_cordic_step.sv
hw/rtl/enu_to_ned_pose_converter.sv
tb/enu_to_ned_pose_converter_tb.sv
